>>> design/brot_pkg.sv
// Shared types, constants and coefficient tables for the 45-degree bitmap rotator.
// No dependencies; every other design file imports this package.
package brot_pkg;

  // Fixed field widths of the row channels.
  localparam int ROW_W     = 32;
  localparam int IDX_W     = 5;
  localparam int STEP_W    = 3;

  // Signed Q2.15 coefficients in 18 bits, with unity held as 2^15.
  localparam int FRAC_BITS = 15;
  localparam int ONE_Q     = 32768;
  localparam int DIAG_Q    = 23170;
  localparam int COEF_W    = 18;

  // Rotation step codes in 45 degree units.
  localparam logic [STEP_W-1:0] STEP_0   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_45  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_90  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_135 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_180 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_225 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_270 = 3'd6;
  localparam logic [STEP_W-1:0] STEP_315 = 3'd7;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_FETCH,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the coordinate unit.
  typedef struct packed {
    logic init;
    logic step_x;
    logic step_row;
  } brot_map_ctl_t;

  // Mapped target of the current source pixel.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } brot_map_res_t;

  // Cosine of the rotation step, exact at right angles.
  function automatic coef_t cos_q(input logic [STEP_W-1:0] step);
    coef_t c;
    case (step)
      STEP_0:   c = coef_t'(ONE_Q);
      STEP_45:  c = coef_t'(DIAG_Q);
      STEP_90:  c = '0;
      STEP_135: c = -coef_t'(DIAG_Q);
      STEP_180: c = -coef_t'(ONE_Q);
      STEP_225: c = -coef_t'(DIAG_Q);
      STEP_270: c = '0;
      STEP_315: c = coef_t'(DIAG_Q);
      default:  c = '0;
    endcase
    return c;
  endfunction

  // Sine of the rotation step, exact at right angles.
  function automatic coef_t sin_q(input logic [STEP_W-1:0] step);
    coef_t s;
    case (step)
      STEP_0:   s = '0;
      STEP_45:  s = coef_t'(DIAG_Q);
      STEP_90:  s = coef_t'(ONE_Q);
      STEP_135: s = coef_t'(DIAG_Q);
      STEP_180: s = '0;
      STEP_225: s = -coef_t'(DIAG_Q);
      STEP_270: s = -coef_t'(ONE_Q);
      STEP_315: s = -coef_t'(DIAG_Q);
      default:  s = '0;
    endcase
    return s;
  endfunction

endpackage

>>> design/brot_if.sv
// Valid/ready channel interfaces for source rows and rotated rows.
// Depends on brot_pkg for the field widths.
interface brot_in_if import brot_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_bits;
  logic [STEP_W-1:0] turn_step;

  modport source (output valid, output row_bits, output turn_step, input ready);
  modport sink   (input valid, input row_bits, input turn_step, output ready);
endinterface

interface brot_out_if import brot_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [IDX_W-1:0] out_row_index;
  logic             out_last;

  modport source (output valid, output out_row, output out_row_index, output out_last,
                  input ready);
  modport sink   (input valid, input out_row, input out_row_index, input out_last,
                  output ready);
endinterface

>>> design/brot_map_unit.sv
// Coordinate unit: incremental Q7.15 accumulators (at SIDE = 32) for the target position of
// each source pixel, with truncation toward zero and bounds check. Uses brot_pkg.
module brot_map_unit import brot_pkg::*; #(
  parameter int SIDE = 32
) (
  input  logic              clk,
  input  brot_map_ctl_t     ctl,
  input  logic [STEP_W-1:0] step,
  output brot_map_res_t     res
);

  localparam int AW     = $clog2(SIDE) + 18;
  localparam int CENTER = SIDE / 2;
  localparam int XN     = (SIDE < ROW_W) ? SIDE : ROW_W;
  localparam logic signed [AW-1:0] CENTER_A = AW'(CENTER);
  localparam logic signed [AW-1:0] ONE_A    = AW'(ONE_Q);

  coef_t                cs_r, sn_r, cs_i, sn_i;
  logic signed [AW-1:0] cs_e, sn_e;
  logic signed [AW-1:0] rx_r, ry_r, nx_r, ny_r;
  logic signed [AW-1:0] nx0, ny0;
  logic signed [AW-1:0] qx, qy;

  // Truncate a Q.15 sum toward zero.
  function automatic logic signed [AW-1:0] trunc0(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] q;
    logic                 fix;
    q   = a >>> FRAC_BITS;
    fix = a[AW-1] && (a[FRAC_BITS-1:0] != '0);
    return q + AW'(fix);
  endfunction

  // Start values for the top-left source pixel, where dx = dy = -center.
  always_comb begin
    cs_i = cos_q(step);
    sn_i = sin_q(step);
    nx0  = CENTER_A * (ONE_A - AW'(cs_i) + AW'(sn_i));
    ny0  = CENTER_A * (ONE_A - AW'(sn_i) - AW'(cs_i));
    cs_e = AW'(cs_r);
    sn_e = AW'(sn_r);
  end

  // Moving one pixel right adds (cos, sin); one row down adds (-sin, cos).
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cs_r <= cs_i;
      sn_r <= sn_i;
      rx_r <= nx0;
      ry_r <= ny0;
      nx_r <= nx0;
      ny_r <= ny0;
    end else if (ctl.step_row) begin
      rx_r <= rx_r - sn_e;
      ry_r <= ry_r + cs_e;
      nx_r <= rx_r - sn_e;
      ny_r <= ry_r + cs_e;
    end else if (ctl.step_x) begin
      nx_r <= nx_r + cs_e;
      ny_r <= ny_r + sn_e;
    end
  end

  // Target position and whether it lands on the shown grid.
  always_comb begin
    qx      = trunc0(nx_r);
    qy      = trunc0(ny_r);
    res.hit = !qx[AW-1] && (qx[AW-2:0] < (AW-1)'(XN))
           && !qy[AW-1] && (qy[AW-2:0] < (AW-1)'(XN));
    res.col = qx[IDX_W-1:0];
    res.row = qy[IDX_W-1:0];
  end

endmodule

>>> design/bitmap_rotate_45_steps.sv
// Bitmap rotator: loads SIDE rows at one per cycle while valid; the last row starts
// the mapping, one source pixel per cycle through the coordinate unit with a row
// fetch before each source row, then min(SIDE,32) rows go out at one per cycle while ready.
// A new frame is loaded only after the last rotated row of the previous one has gone out.
// Reset (synchronous, rst_n low) returns to loading row 0 with step 0; the
// row stores are not cleared, and the destination rows are zeroed per frame.
module bitmap_rotate_45_steps import brot_pkg::*; #(
  parameter int SIDE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  brot_in_if.sink     in_ch,
  brot_out_if.source  out_ch
);

  localparam int RW = $clog2(SIDE);
  localparam int XN = (SIDE < ROW_W) ? SIDE : ROW_W;
  localparam int DW = $clog2(XN);

  state_t            state_r, state_nxt;
  logic [RW-1:0]     row_cnt_r, y_r;
  logic [IDX_W-1:0]  x_r;
  logic [DW-1:0]     e_r;
  logic [STEP_W-1:0] rot_r;

  logic [ROW_W-1:0]  src_mem [SIDE];
  logic [ROW_W-1:0]  src_q_r;
  logic [ROW_W-1:0]  dest_r [XN];

  brot_map_ctl_t     map_ctl;
  brot_map_res_t     map_res;

  logic in_acc, out_acc, last_load, row_end, last_row, last_emit;
  logic src_rd, dest_clr, dest_wr;

  // Shared coordinate unit.
  brot_map_unit #(.SIDE(SIDE)) u_map (
    .clk  (clk),
    .ctl  (map_ctl),
    .step (rot_r),
    .res  (map_res)
  );

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign last_load = (row_cnt_r == RW'(SIDE - 1));
  assign row_end   = (x_r == IDX_W'(XN - 1));
  assign last_row  = (y_r == RW'(SIDE - 1));
  assign last_emit = (e_r == DW'(XN - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (in_acc && last_load) state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (row_end) state_nxt = last_row ? ST_EMIT : ST_FETCH;
      end
      ST_EMIT:  if (out_acc && last_emit) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    map_ctl.init     = 1'b0;
    map_ctl.step_x   = 1'b0;
    map_ctl.step_row = 1'b0;
    src_rd           = 1'b0;
    dest_clr         = 1'b0;
    dest_wr          = 1'b0;
    case (state_r)
      ST_LOAD:  in_ch.ready = 1'b1;
      ST_INIT: begin
        map_ctl.init = 1'b1;
        dest_clr     = 1'b1;
      end
      ST_FETCH: src_rd = 1'b1;
      ST_SCAN: begin
        map_ctl.step_x   = !row_end;
        map_ctl.step_row = row_end;
        dest_wr          = src_q_r[~x_r] && map_res.hit;
      end
      ST_EMIT:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  // Control registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      row_cnt_r <= '0;
      y_r       <= '0;
      x_r       <= '0;
      e_r       <= '0;
      rot_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        row_cnt_r <= last_load ? '0 : row_cnt_r + 1'b1;
        if (row_cnt_r == '0) rot_r <= in_ch.turn_step;
      end
      if (state_r == ST_INIT) begin
        y_r <= '0;
        x_r <= '0;
        e_r <= '0;
      end
      if (state_r == ST_SCAN) begin
        x_r <= row_end ? '0 : x_r + 1'b1;
        if (row_end) y_r <= y_r + 1'b1;
      end
      if (out_acc) e_r <= last_emit ? '0 : e_r + 1'b1;
    end
  end

  // Source row store: written while loading, one row read ahead of each scan.
  always_ff @(posedge clk) begin
    if (in_acc) src_mem[row_cnt_r] <= in_ch.row_bits;
    if (src_rd) src_q_r <= src_mem[y_r];
  end

  // Destination rows: cleared at frame start, set at most one target pixel per cycle during the scan.
  always_ff @(posedge clk) begin
    if (dest_clr) begin
      for (int i = 0; i < XN; i++) dest_r[i] <= '0;
    end else if (dest_wr) begin
      dest_r[map_res.row[DW-1:0]][~map_res.col] <= 1'b1;
    end
  end

  // Rotated row item.
  assign out_ch.out_row       = dest_r[e_r];
  assign out_ch.out_row_index = IDX_W'(e_r);
  assign out_ch.out_last      = last_emit;

endmodule
